// ----- rtl/pt2d_pkg.sv -----
package pt2d_pkg;

    localparam int CoordWidth   = 16;
    localparam int CoefWidth    = 18;
    localparam int OffsetWidth  = 16;
    localparam int CoefFracBits = 14;
    localparam int CfgIdxWidth  = 3;
    localparam int CfgDataWidth = 18;

    typedef enum logic [2:0] {
        ModeTranslate = 3'd0,
        ModeRotate    = 3'd1,
        ModeScale     = 3'd2,
        ModeReflect   = 3'd3,
        ModeShear     = 3'd4
    } t_mode;

    typedef enum logic [2:0] {
        AxisX      = 3'd0,
        AxisY      = 3'd1,
        AxisOrigin = 3'd2,
        AxisDiag   = 3'd3,
        AxisAnti   = 3'd4
    } t_axis;

    typedef enum logic [CfgIdxWidth-1:0] {
        CfgMode       = 3'd0,
        CfgAxis       = 3'd1,
        CfgOffsetX    = 3'd2,
        CfgOffsetY    = 3'd3,
        CfgCoefFirst  = 3'd4,
        CfgCoefSecond = 3'd5
    } t_cfg_idx;

    typedef struct packed {
        logic signed [CoordWidth-1:0] point_x;
        logic signed [CoordWidth-1:0] point_y;
        logic                         last_in;
    } t_point_in;

    typedef struct packed {
        logic signed [CoordWidth-1:0] new_x;
        logic signed [CoordWidth-1:0] new_y;
        logic                         saturated;
        logic                         last_out;
    } t_point_out;

endpackage

// ----- rtl/point_transform_2d.sv -----
// channel   direction  handshake              payload
// request   in         start & !busy          i_point (t_point_in)
// result    out        o_done, one cycle      o_result (t_point_out)
// config    in         i_cfg_we               i_cfg_idx, i_cfg_data
//
// one request per cycle; each accepted request is held in the input register,
// goes through a single arithmetic pass, and lands in the result register
// the pass holds four coordinate-by-coefficient multipliers, one add, round, clip
// synchronous active-low reset clears valids and loads register reset values
// busy stays low: the result side cannot stall, so requests are never held off
module point_transform_2d
    import pt2d_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    start,
    output logic                    busy,
    input  t_point_in               i_point,
    output logic                    o_done,
    output t_point_out              o_result,
    input  logic                    i_cfg_we,
    input  logic [CfgIdxWidth-1:0]  i_cfg_idx,
    input  logic [CfgDataWidth-1:0] i_cfg_data
);

    localparam logic signed [CoordWidth-1:0] CoordMax =
        CoordWidth'((64'sd1 <<< (CoordWidth - 1)) - 64'sd1);
    localparam logic signed [CoordWidth-1:0] CoordMin = ~CoordMax;

    logic [2:0]                    cfg_mode, cfg_axis;
    logic signed [OffsetWidth-1:0] cfg_off_x, cfg_off_y;
    logic signed [CoefWidth-1:0]   cfg_coef1, cfg_coef2;

    logic       accept;
    logic       r_in_vld, n_in_vld;
    t_point_in  r_in;
    logic       r_out_vld, n_out_vld;
    t_point_out r_out, n_out;

    assign busy   = 1'b0;
    assign accept = start & ~busy;

    pt2d_cfg u_cfg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg_we  (i_cfg_we),
        .i_cfg_idx (i_cfg_idx),
        .i_cfg_data(i_cfg_data),
        .o_mode    (cfg_mode),
        .o_axis    (cfg_axis),
        .o_off_x   (cfg_off_x),
        .o_off_y   (cfg_off_y),
        .o_coef1   (cfg_coef1),
        .o_coef2   (cfg_coef2)
    );

    pt2d_xform u_xform (
        .i_point (r_in),
        .i_mode  (cfg_mode),
        .i_axis  (cfg_axis),
        .i_off_x (cfg_off_x),
        .i_off_y (cfg_off_y),
        .i_coef1 (cfg_coef1),
        .i_coef2 (cfg_coef2),
        .o_result(n_out)
    );

    assign n_in_vld  = accept;
    assign n_out_vld = r_in_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_in_vld  <= n_in_vld;
            r_out_vld <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_in <= i_point;
        end
        if (r_in_vld) begin
            r_out <= n_out;
        end
    end

    assign o_done   = r_out_vld;
    assign o_result = r_out;

    a_done_follows_request: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(accept, 2)
    ) else $error("result strobe without a matching request");

    a_request_gives_done: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        accept |-> ##2 o_done
    ) else $error("request produced no result");

    a_last_carried: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_result.last_out == $past(i_point.last_in, 2))
    ) else $error("last marker not carried with its point");

    a_sat_at_limit: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_result.saturated) |->
            (o_result.new_x == CoordMax || o_result.new_x == CoordMin ||
             o_result.new_y == CoordMax || o_result.new_y == CoordMin)
    ) else $error("saturation flag set with no coordinate at a limit");

endmodule

// ----- rtl/pt2d_cfg.sv -----
module pt2d_cfg
    import pt2d_pkg::*;
(
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [CfgIdxWidth-1:0]        i_cfg_idx,
    input  logic [CfgDataWidth-1:0]       i_cfg_data,
    output logic [2:0]                    o_mode,
    output logic [2:0]                    o_axis,
    output logic signed [OffsetWidth-1:0] o_off_x,
    output logic signed [OffsetWidth-1:0] o_off_y,
    output logic signed [CoefWidth-1:0]   o_coef1,
    output logic signed [CoefWidth-1:0]   o_coef2
);

    localparam logic signed [CoefWidth-1:0] CoefOne =
        CoefWidth'(64'sd1 <<< CoefFracBits);

    logic [2:0]                    r_mode, n_mode;
    logic [2:0]                    r_axis, n_axis;
    logic signed [OffsetWidth-1:0] r_off_x, n_off_x;
    logic signed [OffsetWidth-1:0] r_off_y, n_off_y;
    logic signed [CoefWidth-1:0]   r_coef1, n_coef1;
    logic signed [CoefWidth-1:0]   r_coef2, n_coef2;
    logic signed [CoefWidth-1:0]   wr_coef;

    assign wr_coef = $signed(i_cfg_data[CoefWidth-1:0]);

    always_comb begin
        n_mode  = r_mode;
        n_axis  = r_axis;
        n_off_x = r_off_x;
        n_off_y = r_off_y;
        n_coef1 = r_coef1;
        n_coef2 = r_coef2;
        if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CfgMode:       n_mode  = i_cfg_data[2:0];
                CfgAxis:       n_axis  = i_cfg_data[2:0];
                CfgOffsetX:    n_off_x = $signed(i_cfg_data[OffsetWidth-1:0]);
                CfgOffsetY:    n_off_y = $signed(i_cfg_data[OffsetWidth-1:0]);
                CfgCoefFirst:  n_coef1 = wr_coef;
                CfgCoefSecond: n_coef2 = wr_coef;
                default:       n_mode  = r_mode;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= ModeTranslate;
            r_axis  <= AxisX;
            r_off_x <= '0;
            r_off_y <= '0;
            r_coef1 <= CoefOne;
            r_coef2 <= '0;
        end else begin
            r_mode  <= n_mode;
            r_axis  <= n_axis;
            r_off_x <= n_off_x;
            r_off_y <= n_off_y;
            r_coef1 <= n_coef1;
            r_coef2 <= n_coef2;
        end
    end

    assign o_mode  = r_mode;
    assign o_axis  = r_axis;
    assign o_off_x = r_off_x;
    assign o_off_y = r_off_y;
    assign o_coef1 = r_coef1;
    assign o_coef2 = r_coef2;

endmodule

// ----- rtl/pt2d_xform.sv -----
module pt2d_xform
    import pt2d_pkg::*;
(
    input  t_point_in                     i_point,
    input  logic [2:0]                    i_mode,
    input  logic [2:0]                    i_axis,
    input  logic signed [OffsetWidth-1:0] i_off_x,
    input  logic signed [OffsetWidth-1:0] i_off_y,
    input  logic signed [CoefWidth-1:0]   i_coef1,
    input  logic signed [CoefWidth-1:0]   i_coef2,
    output t_point_out                    o_result
);

    localparam int PW = CoordWidth + CoefWidth;
    localparam int SW = PW + 1;
    localparam logic [SW-1:0] Half = SW'(64'd1 << (CoefFracBits - 1));
    localparam logic signed [SW-1:0] SatHi =
        SW'((64'sd1 <<< (CoordWidth - 1)) - 64'sd1);
    localparam logic signed [SW-1:0] SatLo = -SatHi - SW'(1);

    function automatic logic signed [SW-1:0] round_half_away(
        input logic signed [SW-1:0] v
    );
        logic          neg;
        logic [SW-1:0] mag;
        logic [SW-1:0] r;
        neg = v[SW-1];
        mag = neg ? SW'(-v) : SW'(v);
        r   = (mag + Half) >> CoefFracBits;
        return neg ? $signed(-r) : $signed(r);
    endfunction

    logic signed [CoordWidth-1:0] x, y;
    logic signed [SW-1:0]         xs, ys;
    logic signed [PW-1:0]         p_xc1, p_yc2, p_xc2, p_yc1;
    logic signed [SW-1:0]         pre_x, pre_y, rnd_x, rnd_y;
    logic signed [SW-1:0]         ref_x, ref_y, res_x, res_y;
    logic                         clip_x_hi, clip_x_lo, clip_y_hi, clip_y_lo;

    assign x  = i_point.point_x;
    assign y  = i_point.point_y;
    assign xs = SW'(x);
    assign ys = SW'(y);

    assign p_xc1 = x * i_coef1;
    assign p_yc2 = y * i_coef2;
    assign p_xc2 = x * i_coef2;
    assign p_yc1 = y * i_coef1;

    always_comb begin
        pre_x = SW'(p_xc1);
        pre_y = SW'(p_yc2);
        case (i_mode)
            ModeRotate: begin
                pre_x = SW'(p_xc1) - SW'(p_yc2);
                pre_y = SW'(p_xc2) + SW'(p_yc1);
            end
            ModeShear: begin
                pre_x = (xs <<< CoefFracBits) + SW'(p_yc1);
                pre_y = (ys <<< CoefFracBits) + SW'(p_xc2);
            end
            default: begin
                pre_x = SW'(p_xc1);
                pre_y = SW'(p_yc2);
            end
        endcase
    end

    assign rnd_x = round_half_away(pre_x);
    assign rnd_y = round_half_away(pre_y);

    always_comb begin
        ref_x = xs;
        ref_y = ys;
        case (i_axis)
            AxisX:      ref_y = -ys;
            AxisY:      ref_x = -xs;
            AxisOrigin: begin
                ref_x = -xs;
                ref_y = -ys;
            end
            AxisDiag: begin
                ref_x = ys;
                ref_y = xs;
            end
            AxisAnti: begin
                ref_x = -ys;
                ref_y = -xs;
            end
            default: begin
                ref_x = xs;
                ref_y = ys;
            end
        endcase
    end

    always_comb begin
        case (i_mode) inside
            ModeTranslate: begin
                res_x = xs + SW'(i_off_x);
                res_y = ys + SW'(i_off_y);
            end
            ModeRotate, ModeScale, ModeShear: begin
                res_x = rnd_x;
                res_y = rnd_y;
            end
            ModeReflect: begin
                res_x = ref_x;
                res_y = ref_y;
            end
            default: begin
                res_x = xs;
                res_y = ys;
            end
        endcase
    end

    assign clip_x_hi = res_x > SatHi;
    assign clip_x_lo = res_x < SatLo;
    assign clip_y_hi = res_y > SatHi;
    assign clip_y_lo = res_y < SatLo;

    always_comb begin
        o_result.new_x = clip_x_hi ? CoordWidth'(SatHi) :
                         clip_x_lo ? CoordWidth'(SatLo) : CoordWidth'(res_x);
        o_result.new_y = clip_y_hi ? CoordWidth'(SatHi) :
                         clip_y_lo ? CoordWidth'(SatLo) : CoordWidth'(res_y);
        o_result.saturated = clip_x_hi | clip_x_lo | clip_y_hi | clip_y_lo;
        o_result.last_out  = i_point.last_in;
    end

endmodule

// ----- bench/pt2d_checker.sv -----
module pt2d_checker
    import pt2d_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_start,
    input  logic                    i_busy,
    input  t_point_in               i_point,
    input  logic                    i_done,
    input  t_point_out              i_result,
    input  logic                    i_cfg_we,
    input  logic [CfgIdxWidth-1:0]  i_cfg_idx,
    input  logic [CfgDataWidth-1:0] i_cfg_data,
    output int                      o_fail_count,
    output int                      o_pending,
    output int                      o_checked,
    output int                      o_saturated
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MaxReports = 10;

    logic [2:0] cfg_mode;
    logic [2:0] cfg_axis;
    longint     cfg_offset_x;
    longint     cfg_offset_y;
    longint     cfg_coef_first;
    longint     cfg_coef_second;

    t_point_out expected_points[$];
    int         fails = 0;
    int         checked = 0;
    int         sat_seen = 0;

    function automatic longint round_half_away(input longint v);
        longint mag;
        mag = (v < 0) ? -v : v;
        mag = (mag + (longint'(1) <<< (CoefFracBits - 1))) >>> CoefFracBits;
        return (v < 0) ? -mag : mag;
    endfunction

    function automatic longint clip_coord(input longint v, inout logic sat);
        longint hi;
        longint lo;
        hi = (longint'(1) <<< (CoordWidth - 1)) - 1;
        lo = -(longint'(1) <<< (CoordWidth - 1));
        if (v > hi) begin
            sat = 1'b1;
            return hi;
        end
        if (v < lo) begin
            sat = 1'b1;
            return lo;
        end
        return v;
    endfunction

    function automatic t_point_out transform_point(input t_point_in p);
        longint     x;
        longint     y;
        longint     nx;
        longint     ny;
        longint     unity;
        logic       sat;
        t_point_out r;
        x     = longint'(signed'(p.point_x));
        y     = longint'(signed'(p.point_y));
        unity = longint'(1) <<< CoefFracBits;
        nx    = x;
        ny    = y;
        sat   = 1'b0;
        case (cfg_mode)
            ModeTranslate: begin
                nx = x + cfg_offset_x;
                ny = y + cfg_offset_y;
            end
            ModeRotate: begin
                nx = round_half_away(x * cfg_coef_first - y * cfg_coef_second);
                ny = round_half_away(x * cfg_coef_second + y * cfg_coef_first);
            end
            ModeScale: begin
                nx = round_half_away(x * cfg_coef_first);
                ny = round_half_away(y * cfg_coef_second);
            end
            ModeReflect: begin
                case (cfg_axis)
                    AxisX: ny = -y;
                    AxisY: nx = -x;
                    AxisOrigin: begin
                        nx = -x;
                        ny = -y;
                    end
                    AxisDiag: begin
                        nx = y;
                        ny = x;
                    end
                    AxisAnti: begin
                        nx = -y;
                        ny = -x;
                    end
                    default: ;
                endcase
            end
            ModeShear: begin
                nx = round_half_away(x * unity + cfg_coef_first * y);
                ny = round_half_away(y * unity + cfg_coef_second * x);
            end
            default: ;
        endcase
        nx          = clip_coord(nx, sat);
        ny          = clip_coord(ny, sat);
        r.new_x     = nx[CoordWidth-1:0];
        r.new_y     = ny[CoordWidth-1:0];
        r.saturated = sat;
        r.last_out  = p.last_in;
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_point_out exp_point;
        if (!i_rst_n) begin
            cfg_mode        = ModeTranslate;
            cfg_axis        = AxisX;
            cfg_offset_x    = 0;
            cfg_offset_y    = 0;
            cfg_coef_first  = longint'(1) <<< CoefFracBits;
            cfg_coef_second = 0;
            expected_points.delete();
        end else begin
            if (i_done) begin
                if (expected_points.size() == 0) begin
                    fails++;
                    if (fails <= MaxReports) begin
                        $display("unexpected result x=%0d y=%0d sat=%0b last=%0b",
                                 i_result.new_x, i_result.new_y,
                                 i_result.saturated, i_result.last_out);
                    end
                end else begin
                    exp_point = expected_points.pop_front();
                    checked++;
                    if (i_result.saturated === 1'b1) begin
                        sat_seen++;
                    end
                    if (i_result.new_x !== exp_point.new_x ||
                        i_result.new_y !== exp_point.new_y ||
                        i_result.saturated !== exp_point.saturated ||
                        i_result.last_out !== exp_point.last_out) begin
                        fails++;
                        if (fails <= MaxReports) begin
                            $display("mismatch: expected x=%0d y=%0d sat=%0b last=%0b, %s",
                                     exp_point.new_x, exp_point.new_y,
                                     exp_point.saturated, exp_point.last_out,
                                     $sformatf("got x=%0d y=%0d sat=%0b last=%0b",
                                               i_result.new_x, i_result.new_y,
                                               i_result.saturated, i_result.last_out));
                        end
                    end
                end
            end
            if (i_start && !i_busy) begin
                expected_points.push_back(transform_point(i_point));
            end
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CfgMode:       cfg_mode = i_cfg_data[2:0];
                    CfgAxis:       cfg_axis = i_cfg_data[2:0];
                    CfgOffsetX:    cfg_offset_x = longint'(signed'(i_cfg_data[OffsetWidth-1:0]));
                    CfgOffsetY:    cfg_offset_y = longint'(signed'(i_cfg_data[OffsetWidth-1:0]));
                    CfgCoefFirst:  cfg_coef_first = longint'(signed'(i_cfg_data[CoefWidth-1:0]));
                    CfgCoefSecond: cfg_coef_second = longint'(signed'(i_cfg_data[CoefWidth-1:0]));
                    default: ;
                endcase
            end
        end
        o_fail_count <= fails;
        o_pending    <= expected_points.size();
        o_checked    <= checked;
        o_saturated  <= sat_seen;
    end

endmodule

// ----- bench/tb_point_transform_2d.sv -----
module tb_point_transform_2d
    import pt2d_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int NumModes     = 5;
    localparam int CfgSpareLo   = CfgCoefSecond + 1;
    localparam int CfgSpareHi   = (1 << CfgIdxWidth) - 1;
    localparam int ResetCycles  = 5;
    localparam int SettleCycles = 4;
    localparam int RandomPhases = 24;
    localparam int PhaseItems   = 75;
    localparam int TimeoutNs    = 2_000_000;
    localparam int OffsetMax    = 32767;
    localparam int OffsetMin    = -32768;
    localparam int CoefMax      = 131071;
    localparam int CoefMin      = -131072;
    localparam int CoefOne      = 1 << CoefFracBits;
    localparam int CoefHalfSqrt = 11585;

    logic                    clk;
    logic                    rst_n = 1'b0;
    logic                    start = 1'b0;
    logic                    busy;
    t_point_in               req_point = '0;
    logic                    done;
    t_point_out              result;
    logic                    cfg_we = 1'b0;
    logic [CfgIdxWidth-1:0]  cfg_idx = '0;
    logic [CfgDataWidth-1:0] cfg_data = '0;

    int fail_count;
    int pending;
    int checked;
    int saturated;
    int settings = 0;
    int corner_step = 0;

    always begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    point_transform_2d dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .start      (start),
        .busy       (busy),
        .i_point    (req_point),
        .o_done     (done),
        .o_result   (result),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    pt2d_checker check (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_start      (start),
        .i_busy       (busy),
        .i_point      (req_point),
        .i_done       (done),
        .i_result     (result),
        .i_cfg_we     (cfg_we),
        .i_cfg_idx    (cfg_idx),
        .i_cfg_data   (cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked),
        .o_saturated  (saturated)
    );

    function automatic logic signed [CoordWidth-1:0] corner_value(input int k);
        case (k % 4)
            0: return {1'b1, {(CoordWidth-1){1'b0}}};
            1: return {1'b0, {(CoordWidth-1){1'b1}}};
            2: return '0;
            default: return '1;
        endcase
    endfunction

    function automatic logic signed [CoordWidth-1:0] pick_coord();
        logic signed [CoordWidth-1:0] v;
        case ($urandom_range(9, 0))
            0: v = corner_value($urandom_range(3, 0));
            1, 2, 3, 4: v = CoordWidth'(int'($urandom_range(2047, 0)) - 1024);
            default: v = CoordWidth'($urandom());
        endcase
        return v;
    endfunction

    function automatic t_point_in random_point();
        t_point_in p;
        p.point_x = pick_coord();
        p.point_y = pick_coord();
        p.last_in = 1'($urandom_range(1, 0));
        return p;
    endfunction

    function automatic int pick_offset();
        logic signed [OffsetWidth-1:0] v;
        case ($urandom_range(3, 0))
            0: v = $urandom_range(1, 0) ? OffsetWidth'(OffsetMax) : OffsetWidth'(OffsetMin);
            1: v = OffsetWidth'(int'($urandom_range(512, 0)) - 256);
            default: v = OffsetWidth'($urandom());
        endcase
        return int'(v);
    endfunction

    function automatic int pick_coef();
        logic signed [CoefWidth-1:0] v;
        case ($urandom_range(7, 0))
            0: v = $urandom_range(1, 0) ? CoefWidth'(CoefMax) : CoefWidth'(CoefMin);
            1, 2, 3, 4: v = CoefWidth'(int'($urandom_range(2 * CoefOne, 0)) - CoefOne);
            default: v = CoefWidth'($urandom());
        endcase
        return int'(v);
    endfunction

    // hold off until every request has its result
    task automatic settle();
        start <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (SettleCycles) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CfgIdxWidth-1:0] idx,
                             input logic [CfgDataWidth-1:0] data);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        @(posedge clk);
    endtask

    // stray high bits ride along on the narrow registers
    task automatic apply_setting(input logic [2:0] mode, input logic [2:0] axis,
                                 input int ox, input int oy, input int c1, input int c2);
        logic [CfgDataWidth-1:0] noise;
        settle();
        noise = CfgDataWidth'($urandom());
        write_reg(CfgMode, {noise[CfgDataWidth-1:3], mode});
        write_reg(CfgAxis, {noise[CfgDataWidth-4:0], axis});
        write_reg(CfgOffsetX, {noise[CfgDataWidth-1:OffsetWidth], ox[OffsetWidth-1:0]});
        write_reg(CfgOffsetY, {noise[1:0], oy[OffsetWidth-1:0]});
        write_reg(CfgCoefFirst, c1[CoefWidth-1:0]);
        write_reg(CfgCoefSecond, c2[CoefWidth-1:0]);
        if ($urandom_range(1, 0)) begin
            write_reg(CfgIdxWidth'($urandom_range(CfgSpareHi, CfgSpareLo)),
                      CfgDataWidth'($urandom()));
        end
        cfg_we <= 1'b0;
        settings++;
    endtask

    task automatic send_point(input t_point_in p, input int idle_pct);
        while ($urandom_range(99, 0) < idle_pct) begin
            start <= 1'b0;
            @(posedge clk);
        end
        start     <= 1'b1;
        req_point <= p;
        @(posedge clk);
        while (busy) @(posedge clk);
    endtask

    task automatic send_corners(input int count);
        t_point_in p;
        for (int k = 0; k < count; k++) begin
            p.point_x = corner_value(corner_step);
            p.point_y = corner_value(corner_step * 3 + 1);
            p.last_in = corner_step[0];
            corner_step++;
            send_point(p, 0);
        end
    endtask

    initial begin
        int          idle_pct;
        logic [2:0]  mode;
        logic [2:0]  axis;
        repeat (ResetCycles) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: reset values, then each mode at its edges, then an unused mode code
        send_corners(4);
        apply_setting(ModeTranslate, AxisX, OffsetMax, OffsetMin, CoefOne, 0);
        send_corners(3);
        apply_setting(ModeRotate, AxisX, 0, 0, CoefHalfSqrt, CoefHalfSqrt);
        send_corners(3);
        apply_setting(ModeScale, AxisX, 0, 0, CoefMin, CoefMax);
        send_corners(3);
        for (int a = 0; a < 8; a++) begin
            corner_step = 0;
            apply_setting(ModeReflect, 3'(a), 0, 0, CoefOne, 0);
            send_corners(1);
        end
        apply_setting(ModeShear, AxisX, 0, 0, CoefMax, CoefMin);
        send_corners(3);
        apply_setting(3'(NumModes), AxisX, OffsetMax, OffsetMax, CoefMax, CoefMax);
        send_corners(1);

        // random: busy sender, sparse sender, then back to back
        for (int phase = 0; phase < RandomPhases; phase++) begin
            idle_pct = (phase < RandomPhases / 3) ? 34 :
                       (phase < 2 * RandomPhases / 3) ? 86 : 0;
            if (phase % (NumModes + 1) == NumModes) begin
                mode = 3'($urandom_range(7, NumModes));
            end else begin
                mode = 3'(phase % (NumModes + 1));
            end
            axis = 3'($urandom_range(7, 0));
            apply_setting(mode, axis, pick_offset(), pick_offset(), pick_coef(), pick_coef());
            for (int n = 0; n < PhaseItems; n++) begin
                if (phase == RandomPhases / 2 && n == PhaseItems / 2) begin
                    settle();
                end
                send_point(random_point(), idle_pct);
            end
        end

        settle();
        $display("%0d requests checked under %0d register settings, %0d of them saturated",
                 checked, settings, saturated);
        if (fail_count == 0 && pending == 0) begin
            $display("tb_point_transform_2d OK");
        end else begin
            $display("tb_point_transform_2d NOT OK");
        end
        $finish;
    end

    initial begin
        #TimeoutNs;
        $display("tb_point_transform_2d NOT OK");
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/pt2d_pkg.sv
rtl/pt2d_cfg.sv
rtl/pt2d_xform.sv
rtl/point_transform_2d.sv
bench/pt2d_checker.sv
bench/tb_point_transform_2d.sv
